>>> design/cvrma_pkg.sv
// ----------------------------------------------------------------------------
// cvrma_pkg
// Shared codes and widths for the modulation route apply unit.
// ----------------------------------------------------------------------------
package cvrma_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  typedef logic [1:0] sel_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIP  = 2'd2;

  // combining operation
  localparam sel_t OP_ADD = 2'd0;
  localparam sel_t OP_SUB = 2'd1;
  localparam sel_t OP_MUL = 2'd2;

  // modulation base
  localparam sel_t BASE_RAW = 2'd0;
  localparam sel_t BASE_CUR = 2'd1;
  localparam sel_t BASE_PAR = 2'd2;

endpackage

>>> design/cvrma_fxmul.sv
// ----------------------------------------------------------------------------
// cvrma_fxmul
// Signed fixed-point multiply, rounded to nearest with ties toward +inf.
// ----------------------------------------------------------------------------
module cvrma_fxmul #(
  parameter int AW   = 18,
  parameter int BW   = 18,
  parameter int FRAC = 16
) (
  input  logic signed [AW-1:0]        a,
  input  logic signed [BW-1:0]        b,
  output logic signed [AW+BW-FRAC-1:0] y
);

  localparam int PW = AW + BW;
  localparam logic signed [PW-1:0] HALF = {{(PW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;

  assign prod = PW'(a) * PW'(b);
  assign rnd  = prod + HALF;
  // taking the upper bits is a floor shift
  assign y    = rnd[PW-1:FRAC];

endmodule

>>> design/cv_route_modulation_apply_unit.sv
// ----------------------------------------------------------------------------
// cv_route_modulation_apply_unit
// Shapes a modulation source by amount, scale and offset and applies it to
// the target value; optional clamp to [0,1], saturation to DATA_WIDTH.
// Pipeline: five register stages from input accept to result valid (rounded
// multiplies in stages 1-4, two side by side in stage 2; combine and
// saturate in stage 5).
// Throughput: one word per cycle while the output is not stalled; stages with
// no valid word fill while the output is stalled, in_stall rises only when every stage holds a word.
// Reset: synchronous active-low rst_n clears valid bits and config registers.
// ----------------------------------------------------------------------------
module cv_route_modulation_apply_unit
  import cvrma_pkg::*;
#(
  parameter int DATA_WIDTH = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_current_value,
  input  logic        [FRAC_BITS:0]    in_unmodulated_value,
  input  logic signed [FRAC_BITS+1:0]  in_source_value,
  input  logic signed [FRAC_BITS+1:0]  in_amount,
  input  logic signed [FRAC_BITS+1:0]  in_scale_factor,
  input  logic signed [FRAC_BITS+1:0]  in_offset_level,
  input  logic                         in_clamp_now,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_result_value
);

  localparam int F  = FRAC_BITS;
  localparam int D  = DATA_WIDTH;
  localparam int W  = F + 2;
  localparam int W1 = W + 1;
  localparam int KW = W1 + W - F;
  localparam int TW = KW + W1 - F;
  localparam int IW = TW + 2;
  localparam int MW = W + IW - F;
  localparam int BW = MW + 1;
  localparam int CW = ((D > F + 2) ? D : F + 2) + 1;
  localparam int QW = W1 + D - F;
  localparam int PW = CW + BW - F;
  localparam int RW = PW + 1;

  localparam logic signed [W1-1:0] ONE_W1 = {{(W1-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [IW-1:0] ONE_I  = {{(IW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [CW-1:0] ONE_C  = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [RW-1:0] ONE_R  = {{(RW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [RW-1:0] SAT_HI = {{(RW-D+1){1'b0}}, {(D-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  // configuration
  sel_t op_r;
  sel_t base_r;
  logic bip_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_ADD;
      base_r <= BASE_RAW;
      bip_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OP:   op_r   <= cfg_data[1:0];
        REG_BASE: base_r <= cfg_data[1:0];
        REG_BIP:  bip_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // flow control: a stage loads when empty or when the next one moves
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5     = !out_valid_r || !out_stall;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r        <= in_valid;
      if (adv2) v2_r        <= v1_r;
      if (adv3) v3_r        <= v2_r;
      if (adv4) v4_r        <= v3_r;
      if (adv5) out_valid_r <= v4_r;
    end
  end

  // ---------------- stage 1: k = (1-off)*scl, base coefficient
  logic signed [W1-1:0] om_off;
  logic signed [KW-1:0] s1_k_nxt;
  logic signed [W1-1:0] s1_omamt_nxt;
  logic signed [CW-1:0] u_c, p_c, omu, omp, ru, rp;
  logic signed [CW-1:0] s1_c_nxt;

  assign om_off       = ONE_W1 - W1'(in_offset_level);
  assign s1_omamt_nxt = ONE_W1 - W1'(in_amount);

  cvrma_fxmul #(.AW(W1), .BW(W), .FRAC(F)) u_mul_k (
    .a(om_off), .b(in_scale_factor), .y(s1_k_nxt)
  );

  assign u_c = CW'(in_current_value);
  assign p_c = $signed(CW'(in_unmodulated_value));
  assign omu = ONE_C - u_c;
  assign omp = ONE_C - p_c;
  assign ru  = (u_c < omu) ? u_c : omu;
  assign rp  = (p_c < omp) ? p_c : omp;

  always_comb begin
    s1_c_nxt = '0;
    case (op_r)
      OP_ADD: begin
        case (base_r)
          BASE_CUR: s1_c_nxt = bip_r ? ru : omu;
          BASE_PAR: s1_c_nxt = bip_r ? rp : omp;
          default:  s1_c_nxt = '0;
        endcase
      end
      OP_SUB: begin
        case (base_r)
          BASE_CUR: s1_c_nxt = bip_r ? ru : u_c;
          BASE_PAR: s1_c_nxt = bip_r ? rp : p_c;
          default:  s1_c_nxt = '0;
        endcase
      end
      default: s1_c_nxt = '0;
    endcase
  end

  logic signed [D-1:0]  s1_u_r;
  logic signed [W-1:0]  s1_src_r, s1_amt_r, s1_off_r;
  logic signed [KW-1:0] s1_k_r;
  logic signed [CW-1:0] s1_c_r;
  logic signed [W1-1:0] s1_omamt_r;
  logic                 s1_clamp_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_u_r     <= in_current_value;
      s1_src_r   <= in_source_value;
      s1_amt_r   <= in_amount;
      s1_off_r   <= in_offset_level;
      s1_k_r     <= s1_k_nxt;
      s1_c_r     <= s1_c_nxt;
      s1_omamt_r <= s1_omamt_nxt;
      s1_clamp_r <= in_clamp_now;
    end
  end

  // ---------------- stage 2: shaped inner term, (1-amt)*u
  logic signed [W1-1:0] srcp;
  logic signed [TW-1:0] t_prod;
  logic signed [IW-1:0] off_i, t_i;
  logic signed [IW-1:0] s2_inner_nxt;
  logic signed [QW-1:0] s2_q_nxt;

  // bipolar source is shifted into the unipolar range first
  assign srcp = bip_r ? (W1'(s1_src_r) + ONE_W1) : W1'(s1_src_r);

  cvrma_fxmul #(.AW(KW), .BW(W1), .FRAC(F)) u_mul_t (
    .a(s1_k_r), .b(srcp), .y(t_prod)
  );

  assign off_i        = IW'(s1_off_r);
  assign t_i          = IW'(t_prod);
  assign s2_inner_nxt = bip_r ? ((off_i <<< 1) + t_i - ONE_I) : (off_i + t_i);

  cvrma_fxmul #(.AW(W1), .BW(D), .FRAC(F)) u_mul_q (
    .a(s1_omamt_r), .b(s1_u_r), .y(s2_q_nxt)
  );

  logic signed [D-1:0]  s2_u_r;
  logic signed [W-1:0]  s2_amt_r;
  logic signed [W1-1:0] s2_omamt_r;
  logic signed [IW-1:0] s2_inner_r;
  logic signed [CW-1:0] s2_c_r;
  logic signed [QW-1:0] s2_q_r;
  logic                 s2_clamp_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_u_r     <= s1_u_r;
      s2_amt_r   <= s1_amt_r;
      s2_omamt_r <= s1_omamt_r;
      s2_inner_r <= s2_inner_nxt;
      s2_c_r     <= s1_c_r;
      s2_q_r     <= s2_q_nxt;
      s2_clamp_r <= s1_clamp_r;
    end
  end

  // ---------------- stage 3: m = amt * inner
  logic signed [MW-1:0] s3_m_nxt;

  cvrma_fxmul #(.AW(W), .BW(IW), .FRAC(F)) u_mul_m (
    .a(s2_amt_r), .b(s2_inner_r), .y(s3_m_nxt)
  );

  logic signed [D-1:0]  s3_u_r;
  logic signed [W1-1:0] s3_omamt_r;
  logic signed [MW-1:0] s3_m_r;
  logic signed [CW-1:0] s3_c_r;
  logic signed [QW-1:0] s3_q_r;
  logic                 s3_clamp_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_u_r     <= s2_u_r;
      s3_omamt_r <= s2_omamt_r;
      s3_m_r     <= s3_m_nxt;
      s3_c_r     <= s2_c_r;
      s3_q_r     <= s2_q_r;
      s3_clamp_r <= s2_clamp_r;
    end
  end

  // ---------------- stage 4: the one product the operation needs
  logic signed [BW-1:0] m_b, mabs, omam;
  logic signed [CW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] s4_p_nxt;
  logic                 mod_base;

  assign m_b      = BW'(s3_m_r);
  assign mabs     = m_b[BW-1] ? -m_b : m_b;
  assign omam     = BW'(s3_omamt_r) + m_b;
  assign mod_base = (base_r == BASE_CUR) || (base_r == BASE_PAR);
  assign mul_a    = (op_r == OP_MUL) ? CW'(s3_u_r) : s3_c_r;
  assign mul_b    = (op_r == OP_MUL && mod_base) ? (bip_r ? mabs : omam) : m_b;

  cvrma_fxmul #(.AW(CW), .BW(BW), .FRAC(F)) u_mul_p (
    .a(mul_a), .b(mul_b), .y(s4_p_nxt)
  );

  logic signed [D-1:0]  s4_u_r;
  logic signed [MW-1:0] s4_m_r;
  logic signed [PW-1:0] s4_p_r;
  logic signed [QW-1:0] s4_q_r;
  logic                 s4_clamp_r;

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_u_r     <= s3_u_r;
      s4_m_r     <= s3_m_r;
      s4_p_r     <= s4_p_nxt;
      s4_q_r     <= s3_q_r;
      s4_clamp_r <= s3_clamp_r;
    end
  end

  // ---------------- stage 5: combine, clamp, saturate
  logic signed [RW-1:0] u_w, m_w, p_w, q_w, comb_v, clip_v;
  logic signed [D-1:0]  out_result_nxt;

  assign u_w = RW'(s4_u_r);
  assign m_w = RW'(s4_m_r);
  assign p_w = RW'(s4_p_r);
  assign q_w = RW'(s4_q_r);

  always_comb begin
    comb_v = u_w;
    case (op_r)
      OP_ADD: begin
        case (base_r)
          BASE_RAW:           comb_v = u_w + m_w;
          BASE_CUR, BASE_PAR: comb_v = u_w + p_w;
          default:            comb_v = u_w;
        endcase
      end
      OP_SUB: begin
        case (base_r)
          BASE_RAW:           comb_v = u_w - m_w;
          BASE_CUR, BASE_PAR: comb_v = u_w - p_w;
          default:            comb_v = u_w;
        endcase
      end
      OP_MUL: begin
        case (base_r)
          BASE_RAW:           comb_v = p_w;
          BASE_CUR, BASE_PAR: comb_v = bip_r ? (q_w + p_w) : p_w;
          default:            comb_v = u_w;
        endcase
      end
      default: comb_v = u_w;
    endcase
  end

  always_comb begin
    clip_v = comb_v;
    if (s4_clamp_r) begin
      if (comb_v < 0) clip_v = '0;
      else if (comb_v > ONE_R) clip_v = ONE_R;
    end
    if (clip_v > SAT_HI) out_result_nxt = SAT_HI[D-1:0];
    else if (clip_v < SAT_LO) out_result_nxt = SAT_LO[D-1:0];
    else out_result_nxt = clip_v[D-1:0];
  end

  logic signed [D-1:0] out_result_r;

  always_ff @(posedge clk) begin
    if (adv5) out_result_r <= out_result_nxt;
  end

  assign out_result_value = out_result_r;

endmodule

>>> design/cvrma_checker.sv
// ----------------------------------------------------------------------------
// cvrma_checker
// Port-level checks for the modulation route apply unit.
// ----------------------------------------------------------------------------
module cvrma_checker #(
  parameter int DATA_WIDTH = 24
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DATA_WIDTH-1:0] out_result_value
);

  // a held result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a held result word keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_value))
    else $error("result changed while stalled");

  // input backs up only when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // with the output not stalled since the accept, an accepted word comes out at out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && !in_stall && rst_n, 5) &&
    $past(!out_stall && rst_n, 4) && $past(!out_stall && rst_n, 3) &&
    $past(!out_stall && rst_n, 2) && $past(!out_stall && rst_n, 1)
    |-> out_valid)
    else $error("accepted word did not arrive on time");

endmodule

bind cv_route_modulation_apply_unit cvrma_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_cvrma_checker (.*);
